FILE: rtl/core/cross_stencil_star_count_top_assert.svh
// Assertion macros shared by the star counter RTL.
// Expects signals named clk and rst_n in the including module.
`ifndef CROSS_STENCIL_STAR_COUNT_TOP_ASSERT_SVH
`define CROSS_STENCIL_STAR_COUNT_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CSC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/csc_pkg.sv
// Package for the five-point stencil star counter.
// Sizes, register codes and the request types shared by the ctrl, score and top modules.
`default_nettype none

package csc_pkg;

  localparam int MAX_COLUMNS = 1024;
  localparam int MAX_ROWS    = 1024;

  localparam int PX_W    = 8;
  localparam int CFG_W   = 11;
  localparam int IDX_W   = 2;
  localparam int THR_W   = 8;
  localparam int STAR_W  = 20;
  localparam int SUM_W   = 11;
  localparam int COL_W   = $clog2(MAX_COLUMNS);
  localparam int ROW_W   = $clog2(MAX_ROWS);
  localparam int LINE_W  = 2 * PX_W;

  localparam int IN_TDATA_W  = ((PX_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((STAR_W + 7) / 8) * 8;

  localparam logic [STAR_W-1:0] COUNT_MAX = {STAR_W{1'b1}};

  localparam logic [IDX_W-1:0] REG_COLUMN_COUNT   = 2'd0;
  localparam logic [IDX_W-1:0] REG_ROW_COUNT      = 2'd1;
  localparam logic [IDX_W-1:0] REG_STAR_THRESHOLD = 2'd2;

  // One accepted pixel handed from the scan counters to the scoring stage.
  typedef struct packed {
    logic [PX_W-1:0]  pixel;
    logic [COL_W-1:0] col;
    logic             score_en;
    logic             last;
  } item_t;

endpackage

`default_nettype wire

FILE: rtl/core/csc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; contents are undefined until written.
`default_nettype none

module csc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/csc_ctrl.sv
// Configuration registers and raster position counters.
// Uses csc_pkg; feeds the scoring stage and the line memory read port.
`default_nettype none
`include "cross_stencil_star_count_top_assert.svh"

module csc_ctrl
  import csc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  input  wire logic             in_accept,
  input  wire logic [PX_W-1:0]  pixel,
  output item_t                 item,
  output logic [SUM_W-1:0]      thr5,
  output logic                  restart
);

  logic [COL_W-1:0] cols_last_r, cols_last_nxt;
  logic [ROW_W-1:0] rows_last_r, rows_last_nxt;
  logic [THR_W-1:0] thr_r, thr_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             cfg_wr;
  logic [31:0]      cfg_wide;
  logic [COL_W-1:0] cols_last_new;
  logic [ROW_W-1:0] rows_last_new;
  logic             at_col_end;
  logic             at_row_end;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign cfg_wide  = 32'(cfg_data);

  // Sizes are stored as the clamped index of the last column / row.
  always_comb begin
    if (cfg_wide < 32'd3) begin
      cols_last_new = COL_W'(2);
    end else if (cfg_wide > 32'(MAX_COLUMNS)) begin
      cols_last_new = COL_W'(MAX_COLUMNS - 1);
    end else begin
      cols_last_new = COL_W'(cfg_wide - 32'd1);
    end
    if (cfg_wide < 32'd3) begin
      rows_last_new = ROW_W'(2);
    end else if (cfg_wide > 32'(MAX_ROWS)) begin
      rows_last_new = ROW_W'(MAX_ROWS - 1);
    end else begin
      rows_last_new = ROW_W'(cfg_wide - 32'd1);
    end
  end

  assign restart = cfg_wr &&
                   (cfg_index == REG_COLUMN_COUNT || cfg_index == REG_ROW_COUNT);

  assign at_col_end = (col_r == cols_last_r);
  assign at_row_end = (row_r == rows_last_r);

  always_comb begin
    cols_last_nxt = cols_last_r;
    rows_last_nxt = rows_last_r;
    thr_nxt       = thr_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    if (cfg_wr) begin
      unique case (cfg_index)
        REG_COLUMN_COUNT:   cols_last_nxt = cols_last_new;
        REG_ROW_COUNT:      rows_last_nxt = rows_last_new;
        REG_STAR_THRESHOLD: thr_nxt       = cfg_data[THR_W-1:0];
        default:            ;
      endcase
    end
    priority if (restart) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (in_accept) begin
      if (at_col_end) begin
        col_nxt = '0;
        row_nxt = at_row_end ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end else begin
      col_nxt = col_r;
      row_nxt = row_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_last_r <= COL_W'(5);
      rows_last_r <= ROW_W'(5);
      thr_r       <= THR_W'(6);
      col_r       <= '0;
      row_r       <= '0;
    end else begin
      cols_last_r <= cols_last_nxt;
      rows_last_r <= rows_last_nxt;
      thr_r       <= thr_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
    end
  end

  // Scoring lags one column: step c scores centre c-1, interior from column 2.
  assign item.pixel    = pixel;
  assign item.col      = col_r;
  assign item.score_en = (row_r >= ROW_W'(2)) && (col_r >= COL_W'(2));
  assign item.last     = at_col_end && at_row_end;

  assign thr5 = SUM_W'({thr_r, 2'b00}) + SUM_W'(thr_r);

  `CSC_ASSERT_NOW(a_col_in_frame, 1'b1, col_r <= cols_last_r, "column past row end")
  `CSC_ASSERT_NOW(a_row_in_frame, 1'b1, row_r <= rows_last_r, "row past frame end")

endmodule

`default_nettype wire

FILE: rtl/core/csc_score.sv
// Scoring stage: line memory read-modify-write, stencil sum and star count.
// Uses csc_pkg; takes requests from csc_ctrl and data from csc_ram.
`default_nettype none
`include "cross_stencil_star_count_top_assert.svh"

module csc_score
  import csc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_accept,
  input  wire item_t              item,
  input  wire logic [SUM_W-1:0]   thr5,
  input  wire logic               restart,
  input  wire logic [LINE_W-1:0]  rd_data,
  output logic                    wr_en,
  output logic [COL_W-1:0]        wr_addr,
  output logic [LINE_W-1:0]       wr_data,
  output logic                    hold,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [OUT_TDATA_W-1:0]  out_tdata
);

  logic              s1_valid_r, s1_valid_nxt;
  item_t             s1_item_r;
  logic [PX_W-1:0]   n1_r, n2_r, o1_r, p1_r;
  logic [STAR_W-1:0] stars_r, stars_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [STAR_W-1:0] out_data_r;
  logic              fire;
  logic [PX_W-1:0]   rd_newer;
  logic [PX_W-1:0]   rd_older;
  logic [SUM_W-1:0]  sum;
  logic              star;
  logic [STAR_W-1:0] stars_after;

  assign rd_newer = rd_data[PX_W-1:0];
  assign rd_older = rd_data[LINE_W-1:PX_W];

  // Only a frame-end request can wait, and only on a full output register.
  assign hold = s1_valid_r && s1_item_r.last && out_valid_r && !out_tready;
  assign fire = s1_valid_r && !hold;

  // Centre is column c-1 of row r-1; its lower neighbour is the previous pixel.
  assign sum = SUM_W'(n2_r) + SUM_W'(n1_r) + SUM_W'(rd_newer) +
               SUM_W'(o1_r) + SUM_W'(p1_r);
  assign star = s1_item_r.score_en && (sum > thr5);
  assign stars_after = (star && stars_r != COUNT_MAX) ? stars_r + STAR_W'(1) : stars_r;

  assign wr_en   = fire;
  assign wr_addr = s1_item_r.col;
  assign wr_data = {rd_newer, s1_item_r.pixel};

  always_comb begin
    s1_valid_nxt = hold ? s1_valid_r : in_accept;
    stars_nxt    = stars_r;
    if (fire) begin
      stars_nxt = s1_item_r.last ? '0 : stars_after;
    end
    if (restart) begin
      stars_nxt = '0;
    end
    out_valid_nxt = out_valid_r;
    if (fire && s1_item_r.last) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      stars_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      stars_r     <= stars_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!hold && in_accept) begin
      s1_item_r <= item;
    end
    if (fire) begin
      n2_r <= n1_r;
      n1_r <= rd_newer;
      o1_r <= rd_older;
      p1_r <= s1_item_r.pixel;
    end
    if (fire && s1_item_r.last) begin
      out_data_r <= stars_after;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_data_r);

  `CSC_ASSERT_NEXT(a_last_loads_out, fire && s1_item_r.last, out_valid_r,
                   "frame end did not load the result")

endmodule

`default_nettype wire

FILE: rtl/core/cross_stencil_star_count_top.sv
// Five-point stencil star counter, one pixel per clock, raster order.
// A frame's count reaches out_tdata through the scoring stage register and then the output register.
// Throughput: one pixel per cycle, set by one line memory read and write each cycle.
// An unread result drops in_tready only while the next frame-end request waits behind it.
// Reset (rst_n, synchronous): sizes 6x6, threshold 6, counters cleared;
// line memory is not cleared; it is read from the first row, but an entry enters a score only once written.
`default_nettype none

module cross_stencil_star_count_top
  import csc_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // [7:0] pixel
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // [19:0] star_count, rest zero
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [IDX_W-1:0]       cfg_index,
  input  wire logic [CFG_W-1:0]       cfg_data
);

  item_t             item;
  logic [SUM_W-1:0]  thr5;
  logic              restart;
  logic              in_accept;
  logic              hold;
  logic              wr_en;
  logic [COL_W-1:0]  wr_addr;
  logic [LINE_W-1:0] wr_data;
  logic [LINE_W-1:0] rd_data;

  assign in_tready = !hold;
  assign in_accept = in_tvalid && in_tready;

  csc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_accept (in_accept),
    .pixel     (in_tdata[PX_W-1:0]),
    .item      (item),
    .thr5      (thr5),
    .restart   (restart)
  );

  // Each entry holds {row r-2, row r-1} for one column.
  csc_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_COLUMNS)
  ) u_line_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (in_accept),
    .rd_addr (item.col),
    .rd_data (rd_data)
  );

  csc_score u_score (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_accept  (in_accept),
    .item       (item),
    .thr5       (thr5),
    .restart    (restart),
    .rd_data    (rd_data),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .hold       (hold),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire
